// ===== rtl/uwa_pkg.sv =====
package uwa_pkg;

   // Field widths fixed by the interface.
   localparam int ECHO_W = 16;
   localparam int VF_W   = 8;
   localparam int DIST_W = 24;
   localparam int GOOD_W = 5;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_VELOCITY_FACTOR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_RANGE_LIMIT     = 1'b1;

   // Register reset values.
   localparam logic [VF_W-1:0]   VELOCITY_FACTOR_RESET = 8'd17;
   localparam logic [DIST_W-1:0] RANGE_LIMIT_RESET     = 24'd210000;

   // Sequencer states of the averaging back end.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_WAIT
   } back_state_type;

   // Settings handed from the register block to the front end.
   typedef struct packed {
      logic [VF_W-1:0]   velocity_factor;
      logic [DIST_W-1:0] range_limit;
   } cfg_type;

endpackage

// ===== rtl/uwa_queue.sv =====
module uwa_queue #(
   parameter int DATA_W = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              full,
   output logic              empty
);

   // Two entries: one window summary may wait while the back end divides another.
   localparam int DEPTH = 2;

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue popped while empty");

endmodule

// ===== rtl/uwa_front.sv =====
module uwa_front #(
   parameter int WINDOW = 16,
   parameter int CNT_W  = 5,
   parameter int SUM_W  = 29
) (
   input  logic                      clock,
   input  logic                      reset,
   input  uwa_pkg::cfg_type          cfg,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [uwa_pkg::ECHO_W-1:0] req_echo_us,
   input  logic                      q_full,
   output logic                      q_push,
   output logic [SUM_W+CNT_W:0]      q_data
);

   // Stage one: multiply and window position.
   logic                       s1_valid_ff, s1_valid_in;
   logic [uwa_pkg::DIST_W-1:0] s1_dist_ff, s1_dist_in;
   logic                       s1_last_ff, s1_last_in;
   logic [CNT_W-1:0]           sample_count_ff, sample_count_in;

   // Stage two: running sum and valid count.
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           valid_count_ff, valid_count_in;

   logic                       accept;
   logic                       s1_go;
   logic                       dist_ok;
   logic [SUM_W-1:0]           sum_next;
   logic [CNT_W-1:0]           valid_next;

   assign s1_go     = s1_valid_ff && !(s1_last_ff && q_full);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_dist_in = uwa_pkg::DIST_W'(req_echo_us) * uwa_pkg::DIST_W'(cfg.velocity_factor);
      s1_last_in = (sample_count_ff == CNT_W'(WINDOW - 1));
      if (accept) begin
         s1_valid_in     = 1'b1;
         sample_count_in = s1_last_in ? '0 : sample_count_ff + 1'b1;
      end else begin
         s1_valid_in     = s1_valid_ff && !s1_go;
         sample_count_in = sample_count_ff;
      end
   end

   always_comb begin
      dist_ok    = (s1_dist_ff != '0) && (s1_dist_ff <= cfg.range_limit);
      sum_next   = dist_ok ? sum_ff + SUM_W'(s1_dist_ff) : sum_ff;
      valid_next = dist_ok ? valid_count_ff + 1'b1 : valid_count_ff;
      q_push     = s1_go && s1_last_ff;
      // Summary: error flag, valid count, sum of valid distances.
      q_data     = {(valid_next != CNT_W'(WINDOW)), valid_next, sum_next};
      if (s1_go) begin
         sum_in         = s1_last_ff ? '0 : sum_next;
         valid_count_in = s1_last_ff ? '0 : valid_next;
      end else begin
         sum_in         = sum_ff;
         valid_count_in = valid_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         sample_count_ff <= '0;
         sum_ff          <= '0;
         valid_count_ff  <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         sample_count_ff <= sample_count_in;
         sum_ff          <= sum_in;
         valid_count_ff  <= valid_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_dist_ff <= s1_dist_in;
         s1_last_ff <= s1_last_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("window summary pushed into a full queue");

   a_count_in_window: assert property (@(posedge clock) disable iff (reset)
      (sample_count_ff < CNT_W'(WINDOW)) && (valid_count_ff < CNT_W'(WINDOW)))
      else $error("window counters ran past the window length");

endmodule

// ===== rtl/uwa_back.sv =====
module uwa_back #(
   parameter int CNT_W = 5,
   parameter int SUM_W = 29
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  logic [SUM_W+CNT_W:0]       q_data,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [uwa_pkg::DIST_W-1:0] rsp_level,
   output logic                       rsp_some_error,
   output logic                       rsp_all_invalid,
   output logic [uwa_pkg::GOOD_W-1:0] rsp_good_count
);

   localparam int STEP_W = $clog2(SUM_W);

   uwa_pkg::back_state_type state_ff, state_in;

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff;
   logic              err_ff;
   logic [STEP_W-1:0] step_ff, step_in;

   logic              load_div;
   logic              step_en;
   logic              load_out;
   logic              out_free;
   logic [CNT_W:0]    rem_shift;
   logic [CNT_W+1:0]  rem_diff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [uwa_pkg::DIST_W-1:0] rsp_level_ff;
   logic                       rsp_some_error_ff;
   logic                       rsp_all_invalid_ff;
   logic [uwa_pkg::GOOD_W-1:0] rsp_good_count_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         uwa_pkg::BK_IDLE: begin
            if (!q_empty) begin
               state_in = uwa_pkg::BK_DIVIDE;
            end
         end
         uwa_pkg::BK_DIVIDE: begin
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = uwa_pkg::BK_WAIT;
            end
         end
         uwa_pkg::BK_WAIT: begin
            if (out_free) begin
               state_in = uwa_pkg::BK_IDLE;
            end
         end
         default: state_in = uwa_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      load_div = 1'b0;
      step_en  = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         uwa_pkg::BK_IDLE:   load_div = !q_empty;
         uwa_pkg::BK_DIVIDE: step_en  = 1'b1;
         uwa_pkg::BK_WAIT:   load_out = out_free;
         default: begin
            load_div = 1'b0;
         end
      endcase
   end

   assign q_pop = load_div;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      rem_shift = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
      rem_diff  = {1'b0, rem_shift} - {2'b00, div_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      if (load_div) begin
         quo_in  = q_data[SUM_W-1:0];
         rem_in  = '0;
         step_in = '0;
      end else if (step_en) begin
         if (!rem_diff[CNT_W+1]) begin
            rem_in = rem_diff[CNT_W:0];
         end else begin
            rem_in = rem_shift;
         end
         quo_in  = {quo_ff[SUM_W-2:0], !rem_diff[CNT_W+1]};
         step_in = step_ff + 1'b1;
      end
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uwa_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (load_div) begin
         div_ff <= q_data[SUM_W +: CNT_W];
         err_ff <= q_data[SUM_W+CNT_W];
      end
      if (load_out) begin
         rsp_level_ff       <= (div_ff == '0) ? '0 : uwa_pkg::DIST_W'(quo_ff);
         rsp_some_error_ff  <= err_ff;
         rsp_all_invalid_ff <= (div_ff == '0);
         rsp_good_count_ff  <= uwa_pkg::GOOD_W'(div_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_some_error  = rsp_some_error_ff;
   assign rsp_all_invalid = rsp_all_invalid_ff;
   assign rsp_good_count  = rsp_good_count_ff;

   a_none_valid_means_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_all_invalid_ff) |-> (rsp_level_ff == '0) && rsp_some_error_ff)
      else $error("empty window reported a nonzero level or no error");

   a_out_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free && (state_ff == uwa_pkg::BK_WAIT))
      else $error("result register overwritten while held");

endmodule

// ===== rtl/ultrasonic_window_averager.sv =====
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall  req_echo_us (16 bit, microseconds)
// rsp       out        rsp_valid/rsp_stall  rsp_level, rsp_some_error,
//                                           rsp_all_invalid, rsp_good_count
// csr       in         csr_write            csr_index, csr_data (write only)
//
// The front end takes one echo beat per cycle while req_stall is low: a registered
// multiply, then range check and accumulation on the registered distance.
// Each finished window's mean is formed in the back end by the one-bit-per-cycle
// restoring divider, one window at a time.
// Reset is synchronous and active high; it restores the register defaults and
// clears the window counters, the summary queue and the result valid flag.
// The two-entry summary queue lets the front keep accepting beats while a mean is
// being divided or a result beat sits stalled on rsp; the front stalls only when it
// must close a window and the queue is full.
module ultrasonic_window_averager #(
   parameter int WINDOW = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [uwa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [uwa_pkg::DIST_W-1:0]          csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [uwa_pkg::ECHO_W-1:0]          req_echo_us,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [uwa_pkg::DIST_W-1:0]          rsp_level,
   output logic                                rsp_some_error,
   output logic                                rsp_all_invalid,
   output logic [uwa_pkg::GOOD_W-1:0]          rsp_good_count
);

   // Counters must hold WINDOW itself; the sum of WINDOW distances of at most
   // 24 bits each never overflows SUM_W bits.
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = uwa_pkg::DIST_W + CNT_W;
   localparam int Q_W   = SUM_W + CNT_W + 1;

   uwa_pkg::cfg_type cfg_ff, cfg_in;

   logic           q_push;
   logic           q_pop;
   logic           q_full;
   logic           q_empty;
   logic [Q_W-1:0] q_push_data;
   logic [Q_W-1:0] q_pop_data;

   // Configuration registers. User writes only while the block is idle; unenforced.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            uwa_pkg::REG_VELOCITY_FACTOR: cfg_in.velocity_factor = csr_data[uwa_pkg::VF_W-1:0];
            uwa_pkg::REG_RANGE_LIMIT:     cfg_in.range_limit     = csr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.velocity_factor <= uwa_pkg::VELOCITY_FACTOR_RESET;
         cfg_ff.range_limit     <= uwa_pkg::RANGE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: converts echo time to distance, checks it and accumulates the window.
   uwa_front #(
      .WINDOW (WINDOW),
      .CNT_W  (CNT_W),
      .SUM_W  (SUM_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_echo_us (req_echo_us),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_push_data)
   );

   // Window summaries waiting for the divider.
   uwa_queue #(
      .DATA_W (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back end: divides the sum by the valid count and holds the result beat.
   uwa_back #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_pop_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_level       (rsp_level),
      .rsp_some_error  (rsp_some_error),
      .rsp_all_invalid (rsp_all_invalid),
      .rsp_good_count  (rsp_good_count)
   );

endmodule
